/* sv/jak_pkg.sv */
`default_nettype none

package jak_pkg;

    localparam int KEYED_AXES_DEF = 8;
    localparam int MAX_SLOTS      = 16;
    localparam int SLOT_W         = 4;
    localparam int THR_W          = 15;

    localparam logic [THR_W-1:0] THR_RESET = 15'd4915;

    localparam logic       FUNC_EVENT  = 1'b0;
    localparam logic       FUNC_TICK   = 1'b1;
    localparam logic [1:0] KIND_BUTTON = 2'd0;
    localparam logic [1:0] KIND_AXIS   = 2'd1;
    localparam logic       KEY_BUTTON  = 1'b0;
    localparam logic       KEY_SLOT    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               func;
        logic [1:0]         event_kind;
        logic [7:0]         event_number;
        logic signed [15:0] event_value;
    } t_in_word;

    typedef struct packed {
        logic       key_kind;
        logic [7:0] key_index;
        logic       key_down;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic              busy;
        logic              accept;
        logic              scan;
        logic              load_key;
        logic              commit;
        logic [SLOT_W-1:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic diff_bit;
    } t_sts;

endpackage

`default_nettype wire

/* sv/jak_ctrl.sv */
`default_nettype none

module jak_ctrl
    import jak_pkg::*;
#(
    parameter int KEYED_AXES = KEYED_AXES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_func,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam int SLOT_AXES = (KEYED_AXES < 8) ? KEYED_AXES : 8;
    localparam logic [SLOT_W-1:0] SCAN_LAST = SLOT_W'(SLOT_AXES - 1);
    localparam logic [SLOT_W-1:0] EMIT_LAST = SLOT_W'(MAX_SLOTS - 1);

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic              accept;
    logic              emit_hold;

    assign accept    = (r_state == ST_IDLE) && i_in_valid && i_sts.out_free;
    assign emit_hold = i_sts.diff_bit && !i_sts.out_free;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (accept && i_func == FUNC_TICK) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == SCAN_LAST) begin
                    n_state = ST_EMIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!emit_hold) begin
                    if (r_cnt == EMIT_LAST) begin
                        n_state = ST_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.cnt      = r_cnt;
        o_cmd.busy     = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = accept;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.load_key = i_sts.diff_bit && i_sts.out_free;
                o_cmd.commit   = !emit_hold && (r_cnt == EMIT_LAST);
            end
            default: begin
                o_cmd.busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* sv/jak_dpath.sv */
`default_nettype none

module jak_dpath
    import jak_pkg::*;
#(
    parameter int KEYED_AXES = KEYED_AXES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_in_word         i_in_word,
    input  wire logic             i_cfg_valid,
    input  wire logic [THR_W-1:0] i_cfg_data,
    input  wire logic             i_out_stall,
    input  wire t_cmd             i_cmd,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    output t_out_word             o_out_word
);

    localparam int AW = (KEYED_AXES > 1) ? $clog2(KEYED_AXES) : 1;

    logic signed [15:0]    r_axis [KEYED_AXES];
    logic [THR_W-1:0]      r_thr;
    logic [MAX_SLOTS-1:0]  r_bits, n_bits;
    logic [MAX_SLOTS-1:0]  r_prev;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out, n_out;

    logic                  out_free;
    logic [MAX_SLOTS-1:0]  diff;
    logic [MAX_SLOTS-1:0]  upper;
    logic [AW-1:0]         wr_idx;
    logic [AW-1:0]         rd_idx;
    logic                  wr_en;
    logic signed [16:0]    sample;
    logic signed [16:0]    thr_pos;
    logic [SLOT_W-1:0]     slot_neg;
    logic [SLOT_W-1:0]     slot_pos;

    assign out_free = !r_out_valid || !i_out_stall;
    assign diff     = r_bits ^ r_prev;
    assign upper    = diff >> i_cmd.cnt;

    assign o_sts.out_free = out_free;
    assign o_sts.diff_bit = diff[i_cmd.cnt];

    assign wr_idx = i_in_word.event_number[AW-1:0];
    assign wr_en  = i_cmd.accept && i_in_word.func == FUNC_EVENT
                 && i_in_word.event_kind == KIND_AXIS
                 && i_in_word.event_number < 8'(KEYED_AXES);

    assign rd_idx   = AW'(i_cmd.cnt);
    assign sample   = 17'(r_axis[rd_idx]);
    assign thr_pos  = $signed({2'b00, r_thr});
    assign slot_neg = {i_cmd.cnt[SLOT_W-2:0], 1'b0};
    assign slot_pos = {i_cmd.cnt[SLOT_W-2:0], 1'b1};

    always_comb begin
        n_bits = r_bits;
        if (i_cmd.accept) begin
            n_bits = '0;
        end else if (i_cmd.scan) begin
            if (sample < -thr_pos) begin
                n_bits[slot_neg] = 1'b1;
            end else if (sample > thr_pos) begin
                n_bits[slot_pos] = 1'b1;
            end
        end
    end

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (i_cmd.accept && i_in_word.func == FUNC_EVENT
                && i_in_word.event_kind == KIND_BUTTON) begin
            n_out.key_kind  = KEY_BUTTON;
            n_out.key_index = i_in_word.event_number;
            n_out.key_down  = (i_in_word.event_value != '0);
            n_out.last      = 1'b1;
            n_out_valid     = 1'b1;
        end else if (i_cmd.load_key) begin
            n_out.key_kind  = KEY_SLOT;
            n_out.key_index = 8'(i_cmd.cnt);
            n_out.key_down  = r_bits[i_cmd.cnt];
            n_out.last      = (upper[MAX_SLOTS-1:1] == '0);
            n_out_valid     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEYED_AXES; i++) begin
                r_axis[i] <= '0;
            end
            r_thr       <= THR_RESET;
            r_bits      <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_axis[wr_idx] <= i_in_word.event_value;
            end
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            r_bits      <= n_bits;
            if (i_cmd.commit) begin
                r_prev <= r_bits;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

/* sv/joystick_axis_to_key_events.sv */
// Joystick axis to key events.
// Input channel (i_in_valid / o_in_stall, word i_in_word): joystick events
// and poll ticks. Output channel (o_out_valid / i_out_stall, word
// o_out_word): key press and release words, the last one of each input
// marked by its last flag. Config channel (i_cfg_valid / o_cfg_ready,
// always ready): the 15-bit dead zone threshold.
// A button event is taken when the output register is free and its key word
// shows on the next cycle. An axis event emits nothing. A tick scans one
// axis per cycle, min(KEYED_AXES, 8) axes, then walks the 16 direction
// slots one per cycle unless held, emitting a word for each changed slot;
// the input stays stalled until the walk ends. A stalled output holds the
// slot walk only while a changed slot waits for the output register.
// One input is in work at a time.
// Reset clears the axis samples and direction bits and loads threshold 4915.
// While the receiver stalls, the output word holds and o_in_stall stays high
// as long as that word waits, whatever the kind of the next input.
`default_nettype none

module joystick_axis_to_key_events
    import jak_pkg::*;
#(
    parameter int KEYED_AXES = KEYED_AXES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_word         i_in_word,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [THR_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_word             o_out_word
);

    t_cmd cmd;
    t_sts sts;

    jak_ctrl #(
        .KEYED_AXES(KEYED_AXES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_word.func),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    jak_dpath #(
        .KEYED_AXES(KEYED_AXES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    assign o_in_stall  = cmd.busy || !sts.out_free;
    assign o_cfg_ready = 1'b1;

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.func == FUNC_TICK) |=> cmd.busy)
        else $error("tick accepted without entering scan");

    a_button_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.func == FUNC_EVENT
            && i_in_word.event_kind == KIND_BUTTON)
        |=> (o_out_valid && o_out_word.last && o_out_word.key_kind == KEY_BUTTON))
        else $error("button event did not produce a key word");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.busy |-> o_in_stall)
        else $error("input taken while a tick is in work");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_key |-> (sts.out_free && !cmd.accept))
        else $error("key word loaded over a pending word");

endmodule

`default_nettype wire

/* tb/sv/joystick_axis_to_key_events_test.sv */
`default_nettype none

module joystick_axis_to_key_events_test;
    import jak_pkg::*;

    localparam logic [1:0] KIND_OTHER   = 2'd2;
    localparam logic [1:0] KIND_SPARE   = 2'd3;
    localparam int         STORED_AXES  = KEYED_AXES_DEF;
    localparam int         KEYED        = (KEYED_AXES_DEF < 8) ? KEYED_AXES_DEF : 8;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         HOLD_CYCLES  = 250;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    t_in_word         in_word;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data;
    logic             out_valid;
    logic             out_stall;
    t_out_word        out_word;

    logic signed [15:0] axis_store [STORED_AXES];
    logic [15:0]        dir_bits_prev;
    logic [THR_W-1:0]   dead_zone;
    t_out_word          key_words_due [$];

    bit idle_en;
    int hold_request;
    int hold_left;
    int stall_left;
    int fails;
    int words_in;
    int keys_checked;
    int cfg_writes;
    int cycles;

    joystick_axis_to_key_events u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void predict_keys(t_in_word w);
        logic [15:0] now_bits;
        t_out_word   k;
        int          thr;
        int          s;
        int          a;
        int          pushed;
        pushed = 0;
        if (w.func == FUNC_EVENT) begin
            if (w.event_kind == KIND_BUTTON) begin
                k.key_kind  = KEY_BUTTON;
                k.key_index = w.event_number;
                k.key_down  = (w.event_value != 0);
                k.last      = 1'b1;
                key_words_due.push_back(k);
            end else if (w.event_kind == KIND_AXIS && w.event_number < STORED_AXES) begin
                axis_store[w.event_number] = w.event_value;
            end
        end else begin
            thr      = int'(dead_zone);
            now_bits = '0;
            for (a = 0; a < KEYED; a++) begin
                s = axis_store[a];
                if (s < -thr) begin
                    now_bits[2*a] = 1'b1;
                end else if (s > thr) begin
                    now_bits[2*a+1] = 1'b1;
                end
            end
            for (a = 0; a < MAX_SLOTS; a++) begin
                if (now_bits[a] != dir_bits_prev[a]) begin
                    k.key_kind  = KEY_SLOT;
                    k.key_index = 8'(a);
                    k.key_down  = now_bits[a];
                    k.last      = 1'b0;
                    key_words_due.push_back(k);
                    pushed++;
                end
            end
            if (pushed > 0) begin
                key_words_due[key_words_due.size()-1].last = 1'b1;
            end
            dir_bits_prev = now_bits;
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            words_in++;
            predict_keys(in_word);
        end
        if (rst_n && cfg_valid && cfg_ready) begin
            dead_zone = cfg_data;
            cfg_writes++;
        end
    end

    always @(posedge clk) begin
        t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            keys_checked++;
            if (key_words_due.size() == 0) begin
                fails++;
                $display("%0t: key word with none expected, expected nothing actual %h",
                         $time, out_word);
            end else begin
                want = key_words_due.pop_front();
                check_field("key_kind", 8'(want.key_kind), 8'(out_word.key_kind));
                check_field("key_index", want.key_index, out_word.key_index);
                check_field("key_down", 8'(want.key_down), 8'(out_word.key_down));
                check_field("last", 8'(want.last), 8'(out_word.last));
            end
        end
    end

    always @(negedge clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 10);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d key words still due", $time, key_words_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_in_word make_word(logic f, logic [1:0] kind, logic [7:0] num,
                                           logic [15:0] val);
        t_in_word w;
        w.func         = f;
        w.event_kind   = kind;
        w.event_number = num;
        w.event_value  = val;
        return w;
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        int       pick;
        int       v;
        pick = $urandom_range(0, 99);
        w = make_word(FUNC_EVENT, KIND_AXIS, 8'($urandom_range(0, STORED_AXES - 1)),
                      16'($urandom));
        if (pick < 45) begin
            v = $urandom_range(0, 3);
            if (v == 0) begin
                v = int'(dead_zone) + int'($urandom_range(0, 2)) - 1;
                w.event_value = 16'(v);
            end else if (v == 1) begin
                v = -int'(dead_zone) - int'($urandom_range(0, 2)) + 1;
                w.event_value = 16'(v);
            end else if (v == 2) begin
                w.event_value = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            end
        end else if (pick < 70) begin
            w.func       = FUNC_TICK;
            w.event_kind = 2'($urandom);
            w.event_number = 8'($urandom);
        end else if (pick < 90) begin
            w.event_kind   = KIND_BUTTON;
            w.event_number = 8'($urandom);
            if ($urandom_range(0, 1) == 1) begin
                w.event_value = 16'($urandom_range(0, 1));
            end
        end else if ($urandom_range(0, 2) == 0) begin
            w.event_number = 8'($urandom_range(STORED_AXES, 255));
        end else begin
            w.event_kind   = $urandom_range(0, 1) ? KIND_OTHER : KIND_SPARE;
            w.event_number = 8'($urandom);
        end
        return w;
    endfunction

    task automatic send_word(t_in_word w);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic input_idle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (key_words_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_dead_zone(logic [THR_W-1:0] level);
        input_idle();
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= level;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_button_keys();
        idle_en = 1'b1;
        send_word(make_word(FUNC_EVENT, KIND_BUTTON, 8'd0, 16'd0));
        send_word(make_word(FUNC_EVENT, KIND_BUTTON, 8'd255, 16'd1));
        send_word(make_word(FUNC_EVENT, KIND_BUTTON, 8'h55, 16'h8000));
        send_word(make_word(FUNC_EVENT, KIND_BUTTON, 8'hAA, 16'h7FFF));
        send_word(make_word(FUNC_EVENT, KIND_BUTTON, 8'hAA, 16'd0));
    endtask

    task automatic test_axis_edges();
        send_word(make_word(FUNC_EVENT, KIND_AXIS, 8'd0, 16'h8000));
        send_word(make_word(FUNC_EVENT, KIND_AXIS, 8'd7, 16'h7FFF));
        send_word(make_word(FUNC_EVENT, KIND_AXIS, 8'd3, 16'(THR_RESET) + 16'd1));
        send_word(make_word(FUNC_EVENT, KIND_AXIS, 8'd4, -(16'(THR_RESET) + 16'd1)));
        send_word(make_word(FUNC_EVENT, KIND_AXIS, 8'd5, 16'(THR_RESET)));
        send_word(make_word(FUNC_EVENT, KIND_AXIS, 8'd6, -16'(THR_RESET)));
        send_word(make_word(FUNC_TICK, KIND_BUTTON, 8'd0, 16'd0));
        // ignored: out-of-range axes and unknown kinds; then a tick with stray fields, taken as a tick
        send_word(make_word(FUNC_EVENT, KIND_AXIS, 8'(STORED_AXES), 16'h8000));
        send_word(make_word(FUNC_EVENT, KIND_AXIS, 8'd255, 16'h7FFF));
        send_word(make_word(FUNC_EVENT, KIND_OTHER, 8'd1, 16'h8000));
        send_word(make_word(FUNC_EVENT, KIND_SPARE, 8'd2, 16'h7FFF));
        send_word(make_word(FUNC_TICK, KIND_SPARE, 8'hFF, 16'hFFFF));
        send_word(make_word(FUNC_EVENT, KIND_AXIS, 8'd0, 16'd0));
        send_word(make_word(FUNC_EVENT, KIND_AXIS, 8'd3, 16'd0));
        send_word(make_word(FUNC_EVENT, KIND_AXIS, 8'd4, 16'd0));
        send_word(make_word(FUNC_EVENT, KIND_AXIS, 8'd7, 16'd0));
        send_word(make_word(FUNC_TICK, KIND_AXIS, 8'd0, 16'd0));
    endtask

    task automatic test_output_backpressure();
        int a;
        input_idle();
        wait_drained();
        idle_en = 1'b0;
        @(posedge clk);
        hold_request = HOLD_CYCLES;
        for (a = 0; a < KEYED; a++) begin
            send_word(make_word(FUNC_EVENT, KIND_AXIS, 8'(a), a[0] ? 16'h7FFF : 16'h8000));
        end
        send_word(make_word(FUNC_TICK, KIND_BUTTON, 8'd0, 16'd0));
        for (a = 0; a < 4; a++) begin
            send_word(make_word(FUNC_EVENT, KIND_BUTTON, 8'(a * 60), 16'(a[0])));
        end
        for (a = 0; a < 4; a++) begin
            send_word(make_word(FUNC_EVENT, KIND_AXIS, 8'(a), 16'd0));
        end
        send_word(make_word(FUNC_TICK, KIND_BUTTON, 8'd0, 16'd0));
    endtask

    task automatic random_phase(int count, logic [THR_W-1:0] level, bit idling);
        int i;
        set_dead_zone(level);
        for (i = 0; i < count; i++) begin
            idle_en = idling && (i % 40 < 28);
            send_word(random_word());
        end
    endtask

    task automatic test_random_traffic();
        random_phase(70, '0, 1'b1);
        random_phase(70, '1, 1'b1);
        random_phase(70, THR_W'($urandom), 1'b1);
        random_phase(70, THR_RESET, 1'b0);
    endtask

    initial begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_word       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        out_stall     = 1'b0;
        idle_en       = 1'b0;
        hold_request  = 0;
        hold_left     = 0;
        stall_left    = 0;
        fails         = 0;
        words_in      = 0;
        keys_checked  = 0;
        cfg_writes    = 0;
        cycles        = 0;
        dead_zone     = THR_RESET;
        dir_bits_prev = '0;
        foreach (axis_store[i]) axis_store[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_button_keys();
        test_axis_edges();
        test_output_backpressure();
        test_random_traffic();

        input_idle();
        wait_drained();
        $display("Covered %0d input words and %0d key words over %0d dead zone settings,",
                 words_in, keys_checked, cfg_writes + 1);
        $display("including zero and full-scale thresholds and a long output hold-off.");
        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
